FILE: design/brtc_pkg.sv
// Package for the bank row timeout closer.
// Field widths, beat structs, command and scope codes, controller types.
// No dependencies.
package brtc_pkg;

  localparam int TIMER_W    = 10;
  localparam int CMD_W      = 3;
  localparam int SCOPE_W    = 2;
  localparam int RANK_W     = 1;
  localparam int BANKGRP_W  = 2;
  localparam int BANK_W     = 2;
  localparam int ROW_W      = 17;
  localparam int COUNT_W    = 8;

  localparam int RANKS_DEF      = 2;
  localparam int BANKGROUPS_DEF = 4;
  localparam int BANKS_DEF      = 4;
  localparam int ROW_BITS_DEF   = 17;

  localparam logic [TIMER_W-1:0] ROW_CYCLE_RESET = TIMER_W'(48);

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACCESS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OTHER  = 3'd4;

  localparam logic [SCOPE_W-1:0] SCOPE_BANK      = 2'd0;
  localparam logic [SCOPE_W-1:0] SCOPE_SAME_BANK = 2'd1;
  localparam logic [SCOPE_W-1:0] SCOPE_RANK      = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SCOPE_W-1:0]   scope;
    logic [RANK_W-1:0]    rank;
    logic [BANKGRP_W-1:0] bankgroup;
    logic [BANK_W-1:0]    bank;
    logic [ROW_W-1:0]     row;
    logic [COUNT_W-1:0]   bundle_size;
    logic [COUNT_W-1:0]   issued_count;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0]    close_rank;
    logic [BANKGRP_W-1:0] close_bankgroup;
    logic [BANK_W-1:0]    close_bank;
    logic [ROW_W-1:0]     close_row;
    logic                 last_close;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic pop;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_expire;
    logic one_left;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/brtc_ctrl.sv
// Controller of the bank row timeout closer: idle / emit sequencer.
// Depends on brtc_pkg.
module brtc_ctrl
  import brtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.accept = item_valid;
        if (item_valid && status.new_expire) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.pop = status.out_free;
        if (status.out_free && status.one_left) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/brtc_dpath.sv
// Datapath of the bank row timeout closer: bank timers, open rows,
// expiry mask, result register. Depends on brtc_pkg.
module brtc_dpath
  import brtc_pkg::*;
#(
  parameter int RANKS      = RANKS_DEF,
  parameter int BANKGROUPS = BANKGROUPS_DEF,
  parameter int BANKS      = BANKS_DEF,
  parameter int ROW_BITS   = ROW_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [TIMER_W-1:0] cfg_data,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  dp_cmd_t            cmd,
  output dp_status_t         status
);

  localparam int NBANKS = RANKS * BANKGROUPS * BANKS;
  localparam int IDX_W  = (NBANKS > 1) ? $clog2(NBANKS) : 1;
  localparam int RW     = (ROW_BITS < ROW_W) ? ROW_BITS : ROW_W;

  function automatic logic [TIMER_W-1:0] timer_upd(
    input logic [TIMER_W-1:0] cur,
    input logic               clr,
    input logic               ld,
    input logic               one,
    input logic [TIMER_W-1:0] rct
  );
    logic [TIMER_W-1:0] nxt;
    nxt = (cur != '0) ? cur - TIMER_W'(1) : cur;
    if (clr) begin
      nxt = '0;
    end else if (ld) begin
      nxt = rct;
    end else if (one) begin
      nxt = TIMER_W'(1);
    end
    return nxt;
  endfunction

  logic [TIMER_W-1:0] row_cycle_time;
  logic [TIMER_W-1:0] timer      [NBANKS];
  logic [TIMER_W-1:0] timer_next [NBANKS];
  logic [RW-1:0]      open_row   [NBANKS];
  logic [NBANKS-1:0]  expire_now;
  logic [NBANKS-1:0]  act_hit;
  logic [NBANKS-1:0]  mask;
  logic [NBANKS-1:0]  pend_mask;
  logic [RW-1:0]      pend_row;
  logic [NBANKS-1:0]  wr_mask;
  logic [RW-1:0]      wr_row;
  logic               bundle_done;
  logic               one_left;
  logic               out_free;

  logic [IDX_W-1:0]     sel_idx;
  logic [RANK_W-1:0]    sel_rank;
  logic [BANKGRP_W-1:0] sel_bg;
  logic [BANK_W-1:0]    sel_bk;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cycle_time <= ROW_CYCLE_RESET;
    end else if (cfg_valid) begin
      row_cycle_time <= cfg_data;
    end
  end

  assign bundle_done = (item.bundle_size != '0) && (item.issued_count == item.bundle_size);

  // Per-bank decode of the issued command against this bank's address
  for (genvar r = 0; r < RANKS; r++) begin : g_rank
    for (genvar g = 0; g < BANKGROUPS; g++) begin : g_grp
      for (genvar b = 0; b < BANKS; b++) begin : g_bank
        localparam int F = b + g * BANKS + r * BANKS * BANKGROUPS;
        logic rk_m, bg_m, bk_m, clr, acc;
        assign rk_m = (int'(item.rank) == r);
        assign bg_m = (int'(item.bankgroup) == g);
        assign bk_m = (int'(item.bank) == b);
        assign clr  = (item.cmd == CMD_CLOSE) && rk_m &&
                      ((item.scope == SCOPE_RANK) ||
                       ((item.scope == SCOPE_SAME_BANK) && bk_m) ||
                       ((item.scope == SCOPE_BANK) && bg_m && bk_m));
        assign act_hit[F] = (item.cmd == CMD_ACT) && rk_m && bg_m && bk_m;
        assign acc  = (item.cmd == CMD_ACCESS) && bundle_done && rk_m && bg_m && bk_m;
        assign expire_now[F] = (timer[F] == TIMER_W'(1));
        assign timer_next[F] = timer_upd(timer[F], clr, act_hit[F], acc, row_cycle_time);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NBANKS; i++) begin
        timer[i] <= '0;
      end
    end else if (cmd.accept) begin
      for (int i = 0; i < NBANKS; i++) begin
        timer[i] <= timer_next[i];
      end
    end
  end

  // Lowest pending bank in flat order
  always_comb begin
    sel_idx  = '0;
    sel_rank = '0;
    sel_bg   = '0;
    sel_bk   = '0;
    for (int r = RANKS - 1; r >= 0; r--) begin
      for (int g = BANKGROUPS - 1; g >= 0; g--) begin
        for (int b = BANKS - 1; b >= 0; b--) begin
          if (mask[b + g * BANKS + r * BANKS * BANKGROUPS]) begin
            sel_idx  = IDX_W'(b + g * BANKS + r * BANKS * BANKGROUPS);
            sel_rank = RANK_W'(r);
            sel_bg   = BANKGRP_W'(g);
            sel_bk   = BANK_W'(b);
          end
        end
      end
    end
  end

  assign one_left = ((mask & (mask - NBANKS'(1))) == '0);
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.accept) begin
      mask <= expire_now;
    end else if (cmd.pop) begin
      mask[sel_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_mask <= act_hit;
      pend_row  <= RW'(item.row);
    end
  end

  // Defer an activate's row write until the expiring rows have been read out
  always_comb begin
    wr_mask = '0;
    wr_row  = pend_row;
    if (cmd.accept && !(|expire_now)) begin
      wr_mask = act_hit;
      wr_row  = RW'(item.row);
    end else if (cmd.pop && one_left) begin
      wr_mask = pend_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NBANKS; i++) begin
        open_row[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NBANKS; i++) begin
        if (wr_mask[i]) begin
          open_row[i] <= wr_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      result.close_rank      <= sel_rank;
      result.close_bankgroup <= sel_bg;
      result.close_bank      <= sel_bk;
      result.close_row       <= ROW_W'(open_row[sel_idx]);
      result.last_close      <= one_left;
    end
  end

  assign status.new_expire = |expire_now;
  assign status.one_left   = one_left;
  assign status.out_free   = out_free;

endmodule

FILE: design/bank_row_timeout_closer_unit.sv
// Top level of the bank row timeout closer.
// Instantiates brtc_ctrl and brtc_dpath; depends on brtc_pkg.
//
// Timeout row-close policy for a DRAM controller, one countdown timer per
// bank. Each beat on the item channel is one controller cycle: every running
// timer counts down, each timer that stood at one produces a precharge beat
// for its bank and recorded row (ascending rank, group, bank order, the last
// beat of the cycle marked by last_close), then the issued command is applied
// (a close clears the timers in its scope, an activate loads row_cycle_time and
// records the row, the last access of a bundle sets the timer to one). An item
// that expires timers stalls the item channel until the result register has
// handed out its precharge beats, one per cycle while the result side does not
// stall. row_cycle_time is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module bank_row_timeout_closer_unit
  import brtc_pkg::*;
#(
  parameter int RANKS      = RANKS_DEF,
  parameter int BANKGROUPS = BANKGROUPS_DEF,
  parameter int BANKS      = BANKS_DEF,
  parameter int ROW_BITS   = ROW_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TIMER_W-1:0] cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Configuration register lives in the datapath and takes a beat every cycle
  assign cfg_ready = 1'b1;

  brtc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (dp_status),
    .cmd        (dp_cmd)
  );

  brtc_dpath #(
    .RANKS      (RANKS),
    .BANKGROUPS (BANKGROUPS),
    .BANKS      (BANKS),
    .ROW_BITS   (ROW_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (dp_cmd),
    .status       (dp_status)
  );

endmodule
